### src/mlp_sigmoid_inference_defines.svh
// Assertion macros shared by the network inference block.
`ifndef MLP_SIGMOID_INFERENCE_DEFINES_SVH
`define MLP_SIGMOID_INFERENCE_DEFINES_SVH

// Check that holds in the same cycle as its trigger.
`define MLPS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that holds in the cycle after its trigger.
`define MLPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### src/mlpsig_pkg.sv
// Package with types, codes, constants and the sigmoid table of the inference block.
package mlpsig_pkg;

    localparam int DEF_MAX_INPUTS  = 16;
    localparam int DEF_MAX_LAYERS  = 4;
    localparam int DEF_MAX_WIDTH   = 16;
    localparam int DEF_MAX_OUTPUTS = 8;

    localparam int MODE_W     = 2;
    localparam int LAYER_W    = 3;
    localparam int NODE_FLD_W = 4;
    localparam int SRC_FLD_W  = 4;
    localparam int VAL_W      = 16;
    localparam int ACT_W      = 13;
    localparam int OUT_IDX_W  = 3;
    localparam int FRAC_W     = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    localparam int SIG_DEPTH  = 1024;
    localparam int SIG_IDX_W  = 10;

    localparam logic [MODE_W-1:0] MODE_WEIGHT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BIAS   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INPUT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RUN    = 2'd3;

    localparam logic [LAYER_W-1:0] LAYER_OUT = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_INPUTS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_LAYERS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAYER_WIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_OUTPUTS = 3'd3;

    localparam logic [4:0] RST_NUM_INPUTS  = 5'd2;
    localparam logic [2:0] RST_NUM_LAYERS  = 3'd1;
    localparam logic [4:0] RST_LAYER_WIDTH = 5'd2;
    localparam logic [3:0] RST_NUM_OUTPUTS = 4'd1;

    localparam logic signed [VAL_W-1:0] WEIGHT_ONE = 16'sd4096;

    typedef struct packed {
        logic mac_vld;
        logic mac_first;
        logic mac_last;
        logic mac_lnode;
        logic mac_out;
        logic clr_vld;
        logic ld_vld;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_idle;
        logic q_empty;
    } t_dp_stat;

    typedef logic [ACT_W-1:0] t_sig_rom [SIG_DEPTH];

    function automatic int clog2_min1(input int v);
        return (v > 1) ? $clog2(v) : 1;
    endfunction

    // Restoring division, used only while building the table.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int k = 63; k >= 0; k--) begin
            r = {r[62:0], n[k]};
            if (r >= d) begin
                r = r - d;
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ah, al, bh, bl, lo, mid, t;
        ah  = a >> 32;
        al  = a & 64'hFFFF_FFFF;
        bh  = b >> 32;
        bl  = b & 64'hFFFF_FFFF;
        lo  = al * bl;
        mid = ah * bl + al * bh;
        t   = mid + (lo >> 32);
        return ah * bh * 64'd4 + (t >> 30);
    endfunction

    // Entry e is round(4096 / (1 + exp(-(e - 512) / 64))), built from a
    // fixed-point power series of exp(-1/64), truncated after twelve terms.
    function automatic t_sig_rom build_sig();
        t_sig_rom    tab;
        logic [63:0] term, c, e, e40, d;
        term = 64'd1 << 62;
        c    = 64'd1 << 62;
        e    = 64'd1 << 62;
        for (int n = 1; n <= 12; n++) begin
            term = udiv64(term >> 6, 64'(n));
            if ((n % 2) == 1) begin
                c = c - term;
            end else begin
                c = c + term;
            end
        end
        for (int k = 0; k <= 512; k++) begin
            e40 = e >> 22;
            d   = (64'd1 << 40) + e40;
            if (k <= 511) begin
                tab[512 + k] = ACT_W'(udiv64((64'd1 << 53) + d, d << 1));
            end
            if (k >= 1) begin
                tab[512 - k] = ACT_W'(udiv64((e40 << 13) + d, d << 1));
            end
            e = mul_q62(e, c);
        end
        return tab;
    endfunction

    localparam t_sig_rom SIG_ROM = build_sig();

endpackage

### src/mlpsig_ctrl.sv
// Controller: configuration registers, clearing sweep and the run sequencer.
`include "mlp_sigmoid_inference_defines.svh"

module mlpsig_ctrl
    import mlpsig_pkg::*;
#(
    parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
    parameter int MAX_LAYERS  = DEF_MAX_LAYERS,
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS,
    localparam int FANIN   = (MAX_INPUTS > MAX_WIDTH) ? MAX_INPUTS : MAX_WIDTH,
    localparam int W_DEPTH = MAX_LAYERS * MAX_WIDTH * FANIN + MAX_OUTPUTS * MAX_WIDTH,
    localparam int WA_W    = clog2_min1(W_DEPTH),
    localparam int LAY_W   = $clog2(MAX_LAYERS + 1),
    localparam int NODE_W  = clog2_min1((MAX_WIDTH > MAX_OUTPUTS) ? MAX_WIDTH : MAX_OUTPUTS),
    localparam int SRC_W   = clog2_min1(FANIN)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [MODE_W-1:0]     i_in_mode,
    output logic                  o_in_ready,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready,
    output t_dp_cmd               o_cmd,
    output logic [LAY_W-1:0]      o_layer,
    output logic [NODE_W-1:0]     o_node,
    output logic [SRC_W-1:0]      o_src,
    output logic [WA_W-1:0]       o_clr_addr,
    input  t_dp_stat              i_stat
);

    localparam int NI_W = $clog2(MAX_INPUTS + 1);
    localparam int NW_W = $clog2(MAX_WIDTH + 1);
    localparam int NO_W = $clog2(MAX_OUTPUTS + 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_MAC   = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [LAY_W-1:0]  r_l, n_l;
    logic [NODE_W-1:0] r_j, n_j;
    logic [SRC_W-1:0]  r_i, n_i;
    logic [WA_W-1:0]   r_clr, n_clr;

    logic [4:0] r_num_inputs;
    logic [2:0] r_num_layers;
    logic [4:0] r_layer_width;
    logic [3:0] r_num_outputs;

    logic [NI_W-1:0]  eff_ni;
    logic [LAY_W-1:0] eff_nl;
    logic [NW_W-1:0]  eff_nw;
    logic [NO_W-1:0]  eff_no;
    logic [31:0]      cnt32, nodes32;
    logic             is_out, src_last, node_last, run_acc;

    always_comb begin
        eff_ni = (r_num_inputs == '0) ? NI_W'(1) :
                 (32'(r_num_inputs) > MAX_INPUTS) ? NI_W'(MAX_INPUTS) : NI_W'(r_num_inputs);
        eff_nl = (r_num_layers == '0) ? LAY_W'(1) :
                 (32'(r_num_layers) > MAX_LAYERS) ? LAY_W'(MAX_LAYERS) : LAY_W'(r_num_layers);
        eff_nw = (r_layer_width == '0) ? NW_W'(1) :
                 (32'(r_layer_width) > MAX_WIDTH) ? NW_W'(MAX_WIDTH) : NW_W'(r_layer_width);
        eff_no = (r_num_outputs == '0) ? NO_W'(1) :
                 (32'(r_num_outputs) > MAX_OUTPUTS) ? NO_W'(MAX_OUTPUTS) : NO_W'(r_num_outputs);
    end

    assign is_out    = (r_l == eff_nl);
    assign cnt32     = (r_l == '0) ? 32'(eff_ni) : 32'(eff_nw);
    assign nodes32   = is_out ? 32'(eff_no) : 32'(eff_nw);
    assign src_last  = ((32'(r_i) + 32'd1) == cnt32);
    assign node_last = ((32'(r_j) + 32'd1) == nodes32);

    assign o_in_ready  = (r_state == S_IDLE) && i_stat.q_empty;
    assign o_cfg_ready = 1'b1;
    assign run_acc     = i_in_valid && o_in_ready && (i_in_mode == MODE_RUN);

    always_comb begin
        o_cmd.mac_vld   = (r_state == S_MAC);
        o_cmd.mac_first = (r_i == '0);
        o_cmd.mac_last  = src_last;
        o_cmd.mac_lnode = node_last;
        o_cmd.mac_out   = is_out;
        o_cmd.clr_vld   = (r_state == S_CLEAR);
        o_cmd.ld_vld    = i_in_valid && o_in_ready && (i_in_mode != MODE_RUN);
    end

    assign o_layer    = r_l;
    assign o_node     = r_j;
    assign o_src      = r_i;
    assign o_clr_addr = r_clr;

    always_comb begin
        n_state = r_state;
        n_l     = r_l;
        n_j     = r_j;
        n_i     = r_i;
        n_clr   = r_clr;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (32'(r_clr) == (W_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (run_acc) begin
                    n_l     = '0;
                    n_j     = '0;
                    n_i     = '0;
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (src_last) begin
                    n_i = '0;
                    if (node_last) begin
                        n_j     = '0;
                        n_state = S_DRAIN;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_DRAIN: begin
                if (i_stat.pipe_idle) begin
                    if (is_out) begin
                        n_state = S_IDLE;
                    end else begin
                        n_l     = r_l + 1'b1;
                        n_state = S_MAC;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_l           <= '0;
            r_j           <= '0;
            r_i           <= '0;
            r_clr         <= '0;
            r_num_inputs  <= RST_NUM_INPUTS;
            r_num_layers  <= RST_NUM_LAYERS;
            r_layer_width <= RST_LAYER_WIDTH;
            r_num_outputs <= RST_NUM_OUTPUTS;
        end else begin
            r_state <= n_state;
            r_l     <= n_l;
            r_j     <= n_j;
            r_i     <= n_i;
            r_clr   <= n_clr;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_NUM_INPUTS:  r_num_inputs  <= i_cfg_data;
                    REG_NUM_LAYERS:  r_num_layers  <= i_cfg_data[2:0];
                    REG_LAYER_WIDTH: r_layer_width <= i_cfg_data;
                    REG_NUM_OUTPUTS: r_num_outputs <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    `MLPS_ASSERT_NEXT(a_ctrl_run_start, run_acc, r_state == S_MAC)
    `MLPS_ASSERT_SAME(a_ctrl_ready_empty, o_in_ready, i_stat.q_empty)
    `MLPS_ASSERT_NEXT(a_ctrl_drain_hold, (r_state == S_DRAIN) && !i_stat.pipe_idle, r_state == S_DRAIN)

endmodule

### src/mlpsig_dp.sv
// Datapath: weight and bias memories, MAC pipeline, sigmoid lookup and result queue.
`include "mlp_sigmoid_inference_defines.svh"

module mlpsig_dp
    import mlpsig_pkg::*;
#(
    parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
    parameter int MAX_LAYERS  = DEF_MAX_LAYERS,
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS,
    localparam int FANIN   = (MAX_INPUTS > MAX_WIDTH) ? MAX_INPUTS : MAX_WIDTH,
    localparam int HID_W   = MAX_LAYERS * MAX_WIDTH * FANIN,
    localparam int W_DEPTH = HID_W + MAX_OUTPUTS * MAX_WIDTH,
    localparam int WA_W    = clog2_min1(W_DEPTH),
    localparam int LAY_W   = $clog2(MAX_LAYERS + 1),
    localparam int NODE_W  = clog2_min1((MAX_WIDTH > MAX_OUTPUTS) ? MAX_WIDTH : MAX_OUTPUTS),
    localparam int SRC_W   = clog2_min1(FANIN)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic [LAY_W-1:0]        i_layer,
    input  logic [NODE_W-1:0]       i_node,
    input  logic [SRC_W-1:0]        i_src,
    input  logic [WA_W-1:0]         i_clr_addr,
    input  logic [MODE_W-1:0]       i_ld_mode,
    input  logic [LAYER_W-1:0]      i_ld_layer,
    input  logic [NODE_FLD_W-1:0]   i_ld_node,
    input  logic [SRC_FLD_W-1:0]    i_ld_src,
    input  logic signed [VAL_W-1:0] i_ld_value,
    output t_dp_stat                o_stat,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [OUT_IDX_W-1:0]    o_out_index,
    output logic [ACT_W-1:0]        o_out_value,
    output logic                    o_out_last
);

    localparam int HID_B   = MAX_LAYERS * MAX_WIDTH;
    localparam int B_DEPTH = HID_B + MAX_OUTPUTS;
    localparam int BA_W    = clog2_min1(B_DEPTH);
    localparam int IN_IW   = clog2_min1(MAX_INPUTS);
    localparam int ACT_IW  = clog2_min1(MAX_WIDTH);
    localparam int Q_IW    = clog2_min1(MAX_OUTPUTS);
    localparam int Q_CW    = $clog2(MAX_OUTPUTS + 1);
    localparam int SRCV_W  = VAL_W + 1;
    localparam int PROD_W  = VAL_W + SRCV_W;
    localparam int ACC_W   = PROD_W + 1 + $clog2(FANIN + 1);
    localparam int SH_W    = ACC_W - FRAC_W;

    logic signed [VAL_W-1:0] r_wmem [W_DEPTH];
    logic signed [VAL_W-1:0] r_bmem [B_DEPTH];
    logic signed [VAL_W-1:0] r_inp [MAX_INPUTS];
    logic [ACT_W-1:0]        r_act [2][MAX_WIDTH];

    logic [OUT_IDX_W-1:0] r_q_idx [MAX_OUTPUTS];
    logic [ACT_W-1:0]     r_q_val [MAX_OUTPUTS];
    logic                 r_q_last [MAX_OUTPUTS];
    logic [Q_CW-1:0]      r_wr, r_rd;

    logic             ld_out, ld_hid, w_ok, b_ok;
    logic             w_we, b_we;
    logic [WA_W-1:0]  w_wa, ld_wa, mac_wa;
    logic [BA_W-1:0]  b_wa, ld_ba, mac_ba;
    logic signed [VAL_W-1:0]  w_wd, b_wd;
    logic signed [SRCV_W-1:0] src_val;

    logic signed [VAL_W-1:0]  r_wq, r_bq;
    logic signed [SRCV_W-1:0] r_b_src;
    logic                     r_b_vld, r_b_first, r_b_last, r_b_lnode, r_b_out, r_b_bank;
    logic [NODE_W-1:0]        r_b_node;

    logic signed [PROD_W-1:0] r_c_prod;
    logic signed [VAL_W-1:0]  r_c_bias;
    logic                     r_c_vld, r_c_first, r_c_last, r_c_lnode, r_c_out, r_c_bank;
    logic [NODE_W-1:0]        r_c_node;

    logic signed [ACC_W-1:0]  r_d_acc, n_acc;
    logic signed [FRAC_W+VAL_W-1:0] bias_q;
    logic                     r_d_vld, r_d_lnode, r_d_out, r_d_bank;
    logic [NODE_W-1:0]        r_d_node;

    logic signed [SH_W-1:0]   sh;
    logic [VAL_W-1:0]         sat;
    logic [SIG_IDX_W-1:0]     r_e_idx;
    logic                     r_e_vld, r_e_lnode, r_e_out, r_e_bank;
    logic [NODE_W-1:0]        r_e_node;

    logic [ACT_W-1:0]         r_f_sig;
    logic                     r_f_vld, r_f_lnode, r_f_out, r_f_bank;
    logic [NODE_W-1:0]        r_f_node;

    // Load, clear and MAC address decode.
    always_comb begin
        ld_out = (i_ld_layer == LAYER_OUT);
        ld_hid = !ld_out && (32'(i_ld_layer) < MAX_LAYERS);
        w_ok   = ld_out ? ((32'(i_ld_node) < MAX_OUTPUTS) && (32'(i_ld_src) < MAX_WIDTH))
                        : (ld_hid && (32'(i_ld_node) < MAX_WIDTH) && (32'(i_ld_src) < FANIN));
        b_ok   = ld_out ? (32'(i_ld_node) < MAX_OUTPUTS)
                        : (ld_hid && (32'(i_ld_node) < MAX_WIDTH));
        ld_wa  = ld_out ? WA_W'(HID_W + 32'(i_ld_node) * MAX_WIDTH + 32'(i_ld_src))
                        : WA_W'((32'(i_ld_layer) * MAX_WIDTH + 32'(i_ld_node)) * FANIN
                                + 32'(i_ld_src));
        ld_ba  = ld_out ? BA_W'(HID_B + 32'(i_ld_node))
                        : BA_W'(32'(i_ld_layer) * MAX_WIDTH + 32'(i_ld_node));
        mac_wa = i_cmd.mac_out ? WA_W'(HID_W + 32'(i_node) * MAX_WIDTH + 32'(i_src))
                               : WA_W'((32'(i_layer) * MAX_WIDTH + 32'(i_node)) * FANIN
                                       + 32'(i_src));
        mac_ba = i_cmd.mac_out ? BA_W'(HID_B + 32'(i_node))
                               : BA_W'(32'(i_layer) * MAX_WIDTH + 32'(i_node));

        w_we = i_cmd.clr_vld || (i_cmd.ld_vld && (i_ld_mode == MODE_WEIGHT) && w_ok);
        w_wa = i_cmd.clr_vld ? i_clr_addr : ld_wa;
        w_wd = i_cmd.clr_vld ? WEIGHT_ONE : i_ld_value;
        b_we = (i_cmd.clr_vld && (32'(i_clr_addr) < B_DEPTH))
               || (i_cmd.ld_vld && (i_ld_mode == MODE_BIAS) && b_ok);
        b_wa = i_cmd.clr_vld ? BA_W'(i_clr_addr) : ld_ba;
        b_wd = i_cmd.clr_vld ? '0 : i_ld_value;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_wmem[w_wa] <= w_wd;
        end
        r_wq <= r_wmem[mac_wa];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_bmem[b_wa] <= b_wd;
        end
        r_bq <= r_bmem[mac_ba];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_INPUTS; k++) begin
                r_inp[k] <= '0;
            end
        end else if (i_cmd.ld_vld && (i_ld_mode == MODE_INPUT)
                     && (32'(i_ld_node) < MAX_INPUTS)) begin
            r_inp[IN_IW'(i_ld_node)] <= i_ld_value;
        end
    end

    // Layer zero reads the inputs; every later layer reads the bank of the layer before.
    always_comb begin
        if ((i_layer == '0) && !i_cmd.mac_out) begin
            src_val = SRCV_W'(r_inp[IN_IW'(i_src)]);
        end else begin
            src_val = SRCV_W'({1'b0, r_act[!i_layer[0]][ACT_IW'(i_src)]});
        end
    end

    always_comb begin
        bias_q = {r_c_bias, {FRAC_W{1'b0}}};
        n_acc  = (r_c_first ? ACC_W'(bias_q) : r_d_acc) + ACC_W'(r_c_prod);
        sh     = SH_W'(r_d_acc >>> FRAC_W);
        if (sh > SH_W'(32767)) begin
            sat = 16'h7FFF;
        end else if (sh < -SH_W'(32768)) begin
            sat = 16'h8000;
        end else begin
            sat = sh[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_src   <= src_val;
        r_b_first <= i_cmd.mac_first;
        r_b_last  <= i_cmd.mac_last;
        r_b_lnode <= i_cmd.mac_lnode;
        r_b_out   <= i_cmd.mac_out;
        r_b_bank  <= i_layer[0];
        r_b_node  <= i_node;

        r_c_prod  <= PROD_W'(r_wq) * PROD_W'(r_b_src);
        r_c_bias  <= r_bq;
        r_c_first <= r_b_first;
        r_c_last  <= r_b_last;
        r_c_lnode <= r_b_lnode;
        r_c_out   <= r_b_out;
        r_c_bank  <= r_b_bank;
        r_c_node  <= r_b_node;

        if (r_c_vld) begin
            r_d_acc <= n_acc;
        end
        r_d_lnode <= r_c_lnode;
        r_d_out   <= r_c_out;
        r_d_bank  <= r_c_bank;
        r_d_node  <= r_c_node;

        r_e_idx   <= sat[VAL_W-1:VAL_W-SIG_IDX_W] ^ {1'b1, {(SIG_IDX_W-1){1'b0}}};
        r_e_lnode <= r_d_lnode;
        r_e_out   <= r_d_out;
        r_e_bank  <= r_d_bank;
        r_e_node  <= r_d_node;

        r_f_sig   <= SIG_ROM[r_e_idx];
        r_f_lnode <= r_e_lnode;
        r_f_out   <= r_e_out;
        r_f_bank  <= r_e_bank;
        r_f_node  <= r_e_node;

        if (r_f_vld && !r_f_out) begin
            r_act[r_f_bank][ACT_IW'(r_f_node)] <= r_f_sig;
        end
        if (r_f_vld && r_f_out) begin
            r_q_idx[Q_IW'(r_f_node)]  <= OUT_IDX_W'(r_f_node);
            r_q_val[Q_IW'(r_f_node)]  <= r_f_sig;
            r_q_last[Q_IW'(r_f_node)] <= r_f_lnode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_wr    <= '0;
            r_rd    <= '0;
        end else begin
            r_b_vld <= i_cmd.mac_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld && r_c_last;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            if (o_out_valid && i_out_ready && o_out_last) begin
                r_wr <= '0;
                r_rd <= '0;
            end else begin
                if (r_f_vld && r_f_out) begin
                    r_wr <= r_wr + 1'b1;
                end
                if (o_out_valid && i_out_ready) begin
                    r_rd <= r_rd + 1'b1;
                end
            end
        end
    end

    assign o_out_valid = (r_rd != r_wr);
    assign o_out_index = r_q_idx[Q_IW'(r_rd)];
    assign o_out_value = r_q_val[Q_IW'(r_rd)];
    assign o_out_last  = r_q_last[Q_IW'(r_rd)];

    assign o_stat.pipe_idle = !(r_b_vld || r_c_vld || r_d_vld || r_e_vld || r_f_vld);
    assign o_stat.q_empty   = (r_wr == '0);

    `MLPS_ASSERT_SAME(a_dp_port_excl, i_cmd.mac_vld, !i_cmd.clr_vld && !i_cmd.ld_vld)
    `MLPS_ASSERT_NEXT(a_dp_push, r_f_vld && r_f_out, r_wr == $past(r_wr) + 1'b1)
    `MLPS_ASSERT_SAME(a_dp_rd_order, o_out_valid, r_rd < r_wr)

endmodule

### src/mlp_sigmoid_inference.sv
// Top level of the fully connected sigmoid network inference block.
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid/s_axis_tready    tdata, tuser (mode)
//   m_axis    out        m_axis_tvalid/m_axis_tready    tdata, tlast
//   cfg       in         i_cfg_valid/o_cfg_ready        i_cfg_index, i_cfg_data
//
// Load and set items are written as they are taken. A run item steps, per layer,
// through nodes times fan-in products on the single multiply-accumulate pipeline
// and then drains it, since each layer waits for the one before it to be written.
// After reset a clearing sweep runs over all MAX_LAYERS*MAX_WIDTH*max(MAX_INPUTS,
// MAX_WIDTH)+MAX_OUTPUTS*MAX_WIDTH weight entries (1152 by default), zeroing the
// biases as well, with no item accepted. No item is taken until all results of
// the previous run have left; a stalled m_axis holds its item.
module mlp_sigmoid_inference
    import mlpsig_pkg::*;
#(
    parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
    parameter int MAX_LAYERS  = DEF_MAX_LAYERS,
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // layer, node, source, value, zero pad
    input  logic [MODE_W-1:0]     s_axis_tuser,   // mode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,   // out_index, out_value
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int FANIN   = (MAX_INPUTS > MAX_WIDTH) ? MAX_INPUTS : MAX_WIDTH;
    localparam int W_DEPTH = MAX_LAYERS * MAX_WIDTH * FANIN + MAX_OUTPUTS * MAX_WIDTH;
    localparam int WA_W    = clog2_min1(W_DEPTH);
    localparam int LAY_W   = $clog2(MAX_LAYERS + 1);
    localparam int NODE_W  = clog2_min1((MAX_WIDTH > MAX_OUTPUTS) ? MAX_WIDTH : MAX_OUTPUTS);
    localparam int SRC_W   = clog2_min1(FANIN);

    t_dp_cmd              cmd;
    t_dp_stat             stat;
    logic [LAY_W-1:0]     mac_layer;
    logic [NODE_W-1:0]    mac_node;
    logic [SRC_W-1:0]     mac_src;
    logic [WA_W-1:0]      clr_addr;
    logic [OUT_IDX_W-1:0] out_index;
    logic [ACT_W-1:0]     out_value;

    mlpsig_ctrl #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_LAYERS  (MAX_LAYERS),
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_mode   (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd),
        .o_layer     (mac_layer),
        .o_node      (mac_node),
        .o_src       (mac_src),
        .o_clr_addr  (clr_addr),
        .i_stat      (stat)
    );

    mlpsig_dp #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_LAYERS  (MAX_LAYERS),
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_layer     (mac_layer),
        .i_node      (mac_node),
        .i_src       (mac_src),
        .i_clr_addr  (clr_addr),
        .i_ld_mode   (s_axis_tuser),
        .i_ld_layer  (s_axis_tdata[2:0]),
        .i_ld_node   (s_axis_tdata[6:3]),
        .i_ld_src    (s_axis_tdata[10:7]),
        .i_ld_value  (s_axis_tdata[26:11]),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_index (out_index),
        .o_out_value (out_value),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_value, out_index};

endmodule

### bench/mlp_sigmoid_inference_tb.sv
// Self-checking testbench for the sigmoid network inference block.
`timescale 1ns / 100ps

module mlp_sigmoid_inference_tb;
    import mlpsig_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        logic [MODE_W-1:0]     mode;
        logic [LAYER_W-1:0]    layer;
        logic [NODE_FLD_W-1:0] node;
        logic [SRC_FLD_W-1:0]  src;
        logic [VAL_W-1:0]      value;
    } t_cmd;

    typedef struct {
        logic [OUT_IDX_W-1:0] idx;
        logic [ACT_W-1:0]     act;
        logic                 last;
    } t_act_out;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;
    logic [MODE_W-1:0]     s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [15:0]           m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mlp_sigmoid_inference i_dut (.*);

    t_cmd     cmd_q[$];
    t_act_out act_q[$];
    logic     calm;
    int       errors;
    int       n_runs;
    int       n_loads;
    int       n_results;
    int       n_cfg;
    logic     cmd_taken;

    // Network state as the block should hold it.
    logic [ACT_W-1:0]        sig_lut [SIG_DEPTH];
    logic signed [VAL_W-1:0] w_hid [4][16][16];
    logic signed [VAL_W-1:0] w_out [8][16];
    logic signed [VAL_W-1:0] b_hid [4][16];
    logic signed [VAL_W-1:0] b_out [8];
    logic signed [VAL_W-1:0] net_in [16];
    logic [ACT_W-1:0]        bank [2][16];
    logic [4:0]              r_inputs;
    logic [2:0]              r_layers;
    logic [4:0]              r_width;
    logic [3:0]              r_outputs;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    function automatic void make_sigmoid_lut();
        logic [63:0]  term, c, e, e40, d;
        logic [127:0] prod;
        term = 64'd1 << 62;
        c    = 64'd1 << 62;
        e    = 64'd1 << 62;
        for (int n = 1; n <= 12; n++) begin
            term = (term >> 6) / n;
            c = (n % 2 == 1) ? c - term : c + term;
        end
        for (int k = 0; k <= 512; k++) begin
            e40 = e >> 22;
            d   = (64'd1 << 40) + e40;
            if (k <= 511) sig_lut[512 + k] = ACT_W'(((64'd1 << 53) + d) / (d * 2));
            if (k >= 1) sig_lut[512 - k] = ACT_W'(((e40 << 13) + d) / (d * 2));
            prod = 128'(e) * 128'(c);
            e = 64'(prod >> 62);
        end
    endfunction

    function automatic int clamp_cnt(int v, int hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [ACT_W-1:0] neuron(longint acc);
        longint q;
        q = acc >>> FRAC_W;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return sig_lut[(q + 32768) >> 6];
    endfunction

    function automatic void reset_network();
        foreach (w_hid[l, j, s]) w_hid[l][j][s] = WEIGHT_ONE;
        foreach (w_out[j, s]) w_out[j][s] = WEIGHT_ONE;
        foreach (b_hid[l, j]) b_hid[l][j] = '0;
        foreach (b_out[j]) b_out[j] = '0;
        foreach (net_in[i]) net_in[i] = '0;
        foreach (bank[b, j]) bank[b][j] = '0;
        r_inputs  = RST_NUM_INPUTS;
        r_layers  = RST_NUM_LAYERS;
        r_width   = RST_LAYER_WIDTH;
        r_outputs = RST_NUM_OUTPUTS;
    endfunction

    function automatic void apply_cmd(t_cmd c);
        int             ni, nl, nw, no;
        longint         acc;
        logic [ACT_W-1:0] nxt [16];
        t_act_out       r;
        case (c.mode)
            MODE_WEIGHT: begin
                if (c.layer == LAYER_OUT) begin
                    if (c.node < 8) w_out[c.node][c.src] = c.value;
                end else if (c.layer < 4) begin
                    w_hid[c.layer][c.node][c.src] = c.value;
                end
            end
            MODE_BIAS: begin
                if (c.layer == LAYER_OUT) begin
                    if (c.node < 8) b_out[c.node] = c.value;
                end else if (c.layer < 4) begin
                    b_hid[c.layer][c.node] = c.value;
                end
            end
            MODE_INPUT: net_in[c.node] = c.value;
            default: begin
                ni = clamp_cnt(r_inputs, 16);
                nl = clamp_cnt(r_layers, 4);
                nw = clamp_cnt(r_width, 16);
                no = clamp_cnt(r_outputs, 8);
                for (int l = 0; l < nl; l++) begin
                    for (int j = 0; j < nw; j++) begin
                        acc = longint'(b_hid[l][j]) * 4096;
                        for (int s = 0; s < (l == 0 ? ni : nw); s++) begin
                            if (l == 0) acc += longint'(w_hid[l][j][s]) * longint'(net_in[s]);
                            else acc += longint'(w_hid[l][j][s]) *
                                        longint'({1'b0, bank[(l - 1) % 2][s]});
                        end
                        nxt[j] = neuron(acc);
                    end
                    for (int j = 0; j < nw; j++) bank[l % 2][j] = nxt[j];
                end
                for (int j = 0; j < no; j++) begin
                    acc = longint'(b_out[j]) * 4096;
                    for (int s = 0; s < nw; s++)
                        acc += longint'(w_out[j][s]) * longint'({1'b0, bank[(nl - 1) % 2][s]});
                    r.idx  = OUT_IDX_W'(j);
                    r.act  = neuron(acc);
                    r.last = (j == no - 1);
                    act_q = {act_q, r};
                end
            end
        endcase
    endfunction

    // Sender side: one item in flight, refilled at the falling edge.
    always @(posedge i_clk) begin
        cmd_taken <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready) begin
            apply_cmd('{s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[6:3],
                        s_axis_tdata[10:7], s_axis_tdata[26:11]});
            if (s_axis_tuser == MODE_RUN) n_runs++;
            else n_loads++;
        end
    end

    always @(negedge i_clk) begin
        t_cmd c;
        if (i_rst_n && (!s_axis_tvalid || cmd_taken)) begin
            if (cmd_q.size() > 0 && (calm || $urandom_range(99) >= 27)) begin
                c = cmd_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= c.mode;
                s_axis_tdata  <= {5'd0, c.value, c.src, c.node, c.layer};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= calm || $urandom_range(99) >= 27;
    end

    // Receiver side.
    always @(posedge i_clk) begin
        t_act_out x;
        if (m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (act_q.size() == 0) begin
                errors++;
                $display("%0t: expected no item, got idx=%0d value=%0d last=%0b", $time,
                         m_axis_tdata[2:0], m_axis_tdata[15:3], m_axis_tlast);
            end else begin
                x = act_q.pop_front();
                if (m_axis_tdata[2:0] !== x.idx || m_axis_tdata[15:3] !== x.act ||
                    m_axis_tlast !== x.last) begin
                    errors++;
                    $display("%0t: idx/value/last expected %0d/%0d/%0b, got %0d/%0d/%0b",
                             $time, x.idx, x.act, x.last,
                             m_axis_tdata[2:0], m_axis_tdata[15:3], m_axis_tlast);
                end
            end
        end
    end

    task automatic push(input logic [1:0] mode, input int layer, input int node,
                        input int src, input logic [15:0] value);
        t_cmd c;
        c.mode  = mode;
        c.layer = LAYER_W'(layer);
        c.node  = NODE_FLD_W'(node);
        c.src   = SRC_FLD_W'(src);
        c.value = value;
        cmd_q = {cmd_q, c};
    endtask

    task automatic settle();
        wait (cmd_q.size() == 0 && !s_axis_tvalid && act_q.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [4:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_NUM_INPUTS:  r_inputs  = data;
            REG_NUM_LAYERS:  r_layers  = data[2:0];
            REG_LAYER_WIDTH: r_width   = data;
            REG_NUM_OUTPUTS: r_outputs = data[3:0];
            default: ;
        endcase
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input int ni, input int nl, input int nw, input int no);
        settle();
        write_reg(REG_NUM_INPUTS, 5'(ni));
        write_reg(REG_NUM_LAYERS, 5'(nl));
        write_reg(REG_LAYER_WIDTH, 5'(nw));
        write_reg(REG_NUM_OUTPUTS, 5'(no));
    endtask

    initial begin
        int ni, nl, nw, no, k, lay;
        errors = 0; n_runs = 0; n_loads = 0; n_results = 0; n_cfg = 0;
        calm = 1'b0; cmd_taken = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = MODE_WEIGHT;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = REG_NUM_INPUTS; i_cfg_data = '0;
        make_sigmoid_lut();
        reset_network();
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: reset state, extreme values, ignored loads.
        push(MODE_RUN, 0, 0, 0, 16'h0);
        push(MODE_INPUT, 0, 0, 0, 16'h7FFF);
        push(MODE_INPUT, 0, 1, 0, 16'h8000);
        push(MODE_INPUT, 0, 15, 0, 16'h1234);
        push(MODE_WEIGHT, 0, 0, 0, 16'h8000);
        push(MODE_WEIGHT, 3, 15, 15, 16'h7FFF);
        push(MODE_WEIGHT, 4, 7, 15, 16'hC000);
        push(MODE_WEIGHT, 4, 9, 3, 16'h0);
        push(MODE_WEIGHT, 5, 0, 0, 16'h0);
        push(MODE_WEIGHT, 7, 15, 15, 16'hFFFF);
        push(MODE_BIAS, 0, 1, 0, 16'h7FFF);
        push(MODE_BIAS, 4, 0, 0, 16'h8000);
        push(MODE_BIAS, 4, 8, 0, 16'h1000);
        push(MODE_BIAS, 6, 3, 0, 16'h1000);
        push(MODE_RUN, 0, 0, 0, 16'h0);
        push(MODE_RUN, 7, 15, 15, 16'hFFFF);
        configure(16, 4, 16, 8);
        push(MODE_RUN, 0, 0, 0, 16'h0);
        configure(0, 0, 0, 0);
        push(MODE_RUN, 0, 0, 0, 16'h0);
        configure(31, 7, 31, 15);
        write_reg(REG_SPARE_LO, 5'd3);
        write_reg(REG_SPARE_HI, 5'd1);
        push(MODE_RUN, 0, 0, 0, 16'h0);
        configure(1, 1, 1, 1);
        push(MODE_RUN, 0, 0, 0, 16'h0);

        // Random part: mostly small networks, loads aimed at used entries.
        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 8) begin
                configure(16, 4, 16, 8);
            end else if (ph % 4 == 3) begin
                configure($urandom_range(31), $urandom_range(7), $urandom_range(31),
                          $urandom_range(15));
            end else begin
                configure($urandom_range(1, 6), $urandom_range(1, 3), $urandom_range(1, 6),
                          $urandom_range(1, 8));
            end
            settle();
            calm = (ph == 4);
            ni = clamp_cnt(r_inputs, 16);
            nl = clamp_cnt(r_layers, 4);
            nw = clamp_cnt(r_width, 16);
            no = clamp_cnt(r_outputs, 8);
            for (int i = 0; i < 20; i++) begin
                k = $urandom_range(99);
                lay = ($urandom_range(3) == 0) ? 4 : $urandom_range(nl - 1);
                if (k < 8) begin
                    push(2'($urandom_range(2)), $urandom_range(7), $urandom_range(15),
                         $urandom_range(15), 16'($urandom));
                end else if (k < 40) begin
                    push(MODE_WEIGHT, lay, $urandom_range(lay == 4 ? no - 1 : nw - 1),
                         $urandom_range((lay == 0 ? ni : nw) - 1),
                         16'($signed($urandom_range(12000)) - 6000));
                end else if (k < 60) begin
                    push(MODE_BIAS, lay, $urandom_range(lay == 4 ? no - 1 : nw - 1), 0,
                         16'($urandom));
                end else if (k < 85) begin
                    push(MODE_INPUT, 0, $urandom_range(ni - 1), 0, 16'($urandom));
                end else begin
                    push(MODE_RUN, $urandom_range(7), $urandom_range(15), $urandom_range(15),
                         16'($urandom));
                end
            end
            push(MODE_RUN, 0, 0, 0, 16'($urandom));
        end
        settle();
        calm = 1'b0;
        repeat (50) @(posedge i_clk);
        $display("Covered %0d network runs, %0d load items and %0d register writes,",
                 n_runs, n_loads, n_cfg);
        $display("checking %0d output activations.", n_results);
        if (errors == 0 && act_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
